@@ design/biquad_iir_section_macros.svh @@
// ----------------------------------------------------------------------------
// Biquad IIR section: assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_IIR_SECTION_MACROS_SVH
`define BIQUAD_IIR_SECTION_MACROS_SVH

// Same-cycle implication.
`define BIQ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BIQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/biq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Biquad IIR section: package
// Register map, gain format and radix-4 Booth digit decode.
// ----------------------------------------------------------------------------
package biq_pkg;

	// Register map
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_B0,
		REG_B1,
		REG_B2,
		REG_A1,
		REG_A2,
		REG_GAIN
	} reg_idx_t;

	// Output gain, unsigned Q2.14
	localparam int              GAIN_W      = 16;
	localparam int              GAIN_FRAC   = 14;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd8192;
	// zero-extended by at least one bit so the Booth recoding sees it as positive
	localparam int              GAIN_DIGITS = (GAIN_W + 2) / 2;
	localparam int              GAIN_MUL_W  = 2 * GAIN_DIGITS + 1;

	// One radix-4 Booth digit: value in {-2, -1, 0, +1, +2}
	typedef struct packed {
		logic zero;
		logic two;
		logic neg;
	} booth_t;

	function automatic booth_t booth_decode(input logic [2:0] bits);
		booth_t d;
		d.neg  = bits[2];
		d.zero = (bits == 3'b000) || (bits == 3'b111);
		d.two  = (bits == 3'b011) || (bits == 3'b100);
		return d;
	endfunction

endpackage
`default_nettype wire

@@ design/biq_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Biquad IIR section: stream interfaces
// Valid/ready channels for input samples and filtered results.
// ----------------------------------------------------------------------------
interface biq_in_if #(
	parameter int SAMPLE_WIDTH = 24
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface biq_out_if #(
	parameter int SAMPLE_WIDTH = 24
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

@@ design/biquad_iir_section.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Biquad IIR section
// Direct-form-1 biquad with output gain, built on a digit-serial MAC.
// ----------------------------------------------------------------------------
// One sample is taken per transfer on samples and one result leaves per
// transfer on results. The filter sum b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2
// is formed by a single radix-4 Booth multiply-accumulate unit that handles
// one two-bit digit of one operand per cycle, interleaving the five taps. A
// rounding step and a saturation step follow, then the same unit scales by
// out_gain over its GAIN_DIGITS (9) Booth digits, then another rounding
// and saturation step. A new sample is taken only once the result of the
// last one is registered, never while an item is in work. The result sits
// in an output register, so a stalled sink holds only that register: the
// next sample is still taken and worked on, and the block waits at the end
// of that item only if the older result is still unread. Both rescalings
// round half up (add half an LSB, then floor) and clamp to the signed
// sample range; the clamped value is what enters the output history.
// Coefficients are signed Q4.COEF_FRAC_BITS, gain unsigned Q2.14.
// Registers are written by cfg_we/cfg_index/cfg_data; writes to an index
// past out_gain are dropped. Write them only while no item is in flight.
// ----------------------------------------------------------------------------
module biquad_iir_section
	import biq_pkg::*;
#(
	parameter int SAMPLE_WIDTH   = 24,
	parameter int COEF_FRAC_BITS = 22,
	localparam int COEF_W        = COEF_FRAC_BITS + 4,
	localparam int CFG_W         = (COEF_W > GAIN_W) ? COEF_W : GAIN_W
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	biq_in_if.sink                    samples,
	biq_out_if.source                 results,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	// Booth digits per sample operand, and the multiplier shift register width
	// (sign-extended operand plus the implicit zero below bit 0).
	localparam int NDIG   = (SAMPLE_WIDTH + 1) / 2;
	localparam int EXT_W  = 2 * NDIG;
	localparam int MUL_W  = EXT_W + 1;
	// Accumulator: five full products plus headroom for rounding.
	localparam int ACC_W  = SAMPLE_WIDTH + COEF_W + 4;
	localparam int MAXDIG = (NDIG > GAIN_DIGITS) ? NDIG : GAIN_DIGITS;
	localparam int POS_W  = $clog2(MAXDIG);
	localparam int NTAPS  = 5;

	localparam logic signed [COEF_W-1:0] COEF_ONE =
		{{(COEF_W-1){1'b0}}, 1'b1} << COEF_FRAC_BITS;
	localparam logic signed [ACC_W-1:0] HALF_COEF =
		{{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] HALF_GAIN =
		{{(ACC_W-1){1'b0}}, 1'b1} << (GAIN_FRAC - 1);
	localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,  // wait for a sample
		ST_MAC,   // filter sum, one digit of one tap per cycle
		ST_RND,   // add half LSB of Q.COEF_FRAC_BITS
		ST_SAT,   // clamp, update output history
		ST_GMAC,  // gain product, one digit per cycle
		ST_GRND,  // add half LSB of Q.14
		ST_GSAT   // clamp, hand to the output register
	} state_t;

	state_t state_q;

	// Configuration
	logic signed [COEF_W-1:0] coef_q [NTAPS];
	logic [GAIN_W-1:0]        gain_q;

	// Filter history
	logic signed [SAMPLE_WIDTH-1:0] x_hist1_q, x_hist2_q, y_hist1_q, y_hist2_q;

	// Sequencer
	logic [CFG_IDX_W-1:0] lane_q;  // tap in work, numbered as the register map
	logic [POS_W-1:0]     pos_q;   // digit position, counts down

	// Datapath
	logic [MUL_W-1:0]        mul_q [NTAPS];
	logic [GAIN_MUL_W-1:0]   gmul_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] rsum_q;

	// Output register
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] out_q;

	logic in_xfer, out_xfer, out_load;

	logic [2:0]               mul_top;
	booth_t                   bd;
	logic                     neg;
	logic signed [ACC_W-1:0]  mcand, mag, addend, base, acc_next;
	logic signed [ACC_W-1:0]  sat_src;
	logic [ACC_W-SAMPLE_WIDTH:0] sat_top;
	logic                     ovf;
	logic signed [SAMPLE_WIDTH-1:0] sat_val;

	assign samples.ready      = (state_q == ST_IDLE);
	assign results.valid      = out_valid_q;
	assign results.sample_out = out_q;

	assign in_xfer  = samples.valid && samples.ready;
	assign out_xfer = out_valid_q && results.ready;
	// load the output register once the previous result is gone or leaving now
	assign out_load = (state_q == ST_GSAT) && (!out_valid_q || results.ready);

	// MAC: acc <- 4*acc + d*m on the first tap of a digit position (and on every
	// gain digit), acc <- acc + d*m on the others. Feedback taps take -d.
	always_comb begin
		if (state_q == ST_GMAC) begin
			mul_top = gmul_q[GAIN_MUL_W-1 -: 3];
			mcand   = ACC_W'(y_hist1_q);
		end else begin
			mul_top = mul_q[lane_q][MUL_W-1 -: 3];
			mcand   = ACC_W'(coef_q[lane_q]);
		end
		bd       = booth_decode(mul_top);
		neg      = bd.neg ^ ((state_q == ST_MAC) && (lane_q == REG_A1 || lane_q == REG_A2));
		mag      = bd.zero ? '0 : (bd.two ? (mcand <<< 1) : mcand);
		addend   = neg ? -mag : mag;
		base     = ((state_q == ST_GMAC) || (lane_q == REG_B0)) ? (acc_q <<< 2) : acc_q;
		acc_next = base + addend;
	end

	// Clamp the rounded sum: the bits above the sample's sign must all match it.
	always_comb begin
		sat_src = (state_q == ST_SAT) ? (rsum_q >>> COEF_FRAC_BITS) : (rsum_q >>> GAIN_FRAC);
		sat_top = sat_src[ACC_W-1:SAMPLE_WIDTH-1];
		ovf     = !((&sat_top) || !(|sat_top));
		if (ovf) begin
			sat_val = sat_src[ACC_W-1] ? S_MIN : S_MAX;
		end else begin
			sat_val = sat_src[SAMPLE_WIDTH-1:0];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[REG_B0] <= COEF_ONE;
			coef_q[REG_B1] <= '0;
			coef_q[REG_B2] <= '0;
			coef_q[REG_A1] <= '0;
			coef_q[REG_A2] <= '0;
			gain_q         <= GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_B0, REG_B1, REG_B2, REG_A1, REG_A2: begin
					coef_q[cfg_index] <= cfg_data[COEF_W-1:0];
				end
				REG_GAIN: begin
					gain_q <= cfg_data[GAIN_W-1:0];
				end
				default: begin
					// unmapped index: drop
				end
			endcase
		end
	end

	// Sequencer, history and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lane_q      <= REG_B0;
			pos_q       <= '0;
			x_hist1_q   <= '0;
			x_hist2_q   <= '0;
			y_hist1_q   <= '0;
			y_hist2_q   <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						// the taps read the shift registers, so shift x history now
						x_hist2_q <= x_hist1_q;
						x_hist1_q <= samples.sample_in;
						lane_q    <= REG_B0;
						pos_q     <= POS_W'(NDIG - 1);
						state_q   <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (lane_q == REG_A2) begin
						lane_q <= REG_B0;
						if (pos_q == '0) begin
							state_q <= ST_RND;
						end else begin
							pos_q <= pos_q - 1'b1;
						end
					end else begin
						lane_q <= lane_q + 1'b1;
					end
				end
				ST_RND: begin
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					y_hist2_q <= y_hist1_q;
					y_hist1_q <= sat_val;
					pos_q     <= POS_W'(GAIN_DIGITS - 1);
					state_q   <= ST_GMAC;
				end
				ST_GMAC: begin
					if (pos_q == '0) begin
						state_q <= ST_GRND;
					end else begin
						pos_q <= pos_q - 1'b1;
					end
				end
				ST_GRND: begin
					state_q <= ST_GSAT;
				end
				ST_GSAT: begin
					// hold here while the previous result is still unread
					if (out_load) begin
						out_q   <= sat_val;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					acc_q           <= '0;
					mul_q[REG_B0]   <= {EXT_W'(samples.sample_in), 1'b0};
					mul_q[REG_B1]   <= {EXT_W'(x_hist1_q), 1'b0};
					mul_q[REG_B2]   <= {EXT_W'(x_hist2_q), 1'b0};
					mul_q[REG_A1]   <= {EXT_W'(y_hist1_q), 1'b0};
					mul_q[REG_A2]   <= {EXT_W'(y_hist2_q), 1'b0};
				end
			end
			ST_MAC: begin
				acc_q <= acc_next;
				// advance all taps to the next digit after the last tap
				if (lane_q == REG_A2) begin
					for (int k = 0; k < NTAPS; k++) begin
						mul_q[k] <= mul_q[k] << 2;
					end
				end
			end
			ST_RND: begin
				rsum_q <= acc_q + HALF_COEF;
			end
			ST_SAT: begin
				acc_q  <= '0;
				gmul_q <= {2'b00, gain_q, 1'b0};
			end
			ST_GMAC: begin
				acc_q  <= acc_next;
				gmul_q <= gmul_q << 2;
			end
			ST_GRND: begin
				rsum_q <= acc_q + HALF_GAIN;
			end
			ST_GSAT: begin
				// result is taken by the output register
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

@@ design/biq_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Biquad IIR section: port checker
// Watches the stream ports and the count of items in flight.
// ----------------------------------------------------------------------------
`include "biquad_iir_section_macros.svh"

module biq_checker #(
	parameter int SAMPLE_WIDTH = 24
) (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_valid,
	input wire logic                    in_ready,
	input wire logic                    out_valid,
	input wire logic                    out_ready,
	input wire logic [SAMPLE_WIDTH-1:0] out_data
);

	logic       in_xfer, out_xfer;
	logic [1:0] pend_q;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// items taken in whose result has not yet left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_xfer && !in_xfer) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	`BIQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped or changed while stalled")
	`BIQ_ASSERT_NEXT(a_one_at_a_time, in_xfer, !in_ready, "sample accepted while another is in work")
	`BIQ_ASSERT_SAME(a_no_phantom, out_valid, pend_q != 2'd0, "result without a pending sample")
	`BIQ_ASSERT_SAME(a_pend_bound, 1'b1, pend_q != 2'd3, "more than two samples in flight")

endmodule

bind biquad_iir_section biq_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_biq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  (results.sample_out)
);
`default_nettype wire

@@ tb/sv/tb_biquad_iir_section.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Biquad IIR section: testbench
// Drives samples through the stream interfaces and predicts every filtered
// result with a fixed-point direct-form-1 model kept in step with the
// register writes. Covers reset defaults, rounding ties, saturation of the
// sum and of the gain stage, clamped feedback history and unmapped register
// writes. Long randomised runs follow, with stalls on both channels.
// ----------------------------------------------------------------------------
module tb_biquad_iir_section
	import biq_pkg::*;
();

	localparam int SW           = 24;
	localparam int COEF_FRAC    = 22;
	localparam int COEF_W       = COEF_FRAC + 4;
	localparam int CFG_W        = (COEF_W > GAIN_W) ? COEF_W : GAIN_W;
	localparam int HALF_PERIOD  = 2;
	localparam int RESET_CYCLES = 7;
	// cycles from one accepted sample to the next at the default width
	localparam int ITEM_CYCLES  = 5 * ((SW + 1) / 2) + 14;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS  = 127;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int MAX_REPORTS  = 10;
	localparam int MAX_BURST    = 17;

	localparam longint SAMPLE_MAX = (longint'(1) << (SW - 1)) - 1;
	localparam longint SAMPLE_MIN = -(longint'(1) << (SW - 1));

	// Coefficient and gain landmarks, signed Q4.22 and unsigned Q2.14
	localparam int COEF_ONE = 1 << COEF_FRAC;
	localparam int COEF_MAX = (1 << (COEF_W - 1)) - 1;
	localparam int COEF_MIN = -(1 << (COEF_W - 1));
	localparam int GAIN_ONE = 1 << GAIN_FRAC;
	localparam int GAIN_MAX = (1 << GAIN_W) - 1;

	// Register indexes past the map: writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] UNMAPPED_FIRST = CFG_IDX_W'(REG_GAIN + 1);
	localparam logic [CFG_IDX_W-1:0] UNMAPPED_LAST  = '1;

	typedef enum int {
		SET_GENTLE,
		SET_FULL,
		SET_CORNERS
	} coef_style_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	biq_in_if  #(.SAMPLE_WIDTH(SW)) samples_ch ();
	biq_out_if #(.SAMPLE_WIDTH(SW)) results_ch ();

	biquad_iir_section #(
		.SAMPLE_WIDTH   (SW),
		.COEF_FRAC_BITS (COEF_FRAC)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_ch),
		.results   (results_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Filter state as the block should hold it: taps, gain and the two
	// histories, updated on every write and every accepted sample.
	logic signed [COEF_W-1:0] tap_b0, tap_b1, tap_b2, tap_a1, tap_a2;
	logic        [GAIN_W-1:0] gain_q14;
	logic signed [SW-1:0]     x_prev1, x_prev2, y_prev1, y_prev2;

	// Filtered samples still owed by the block, oldest first
	logic signed [SW-1:0] owed_samples[$];

	int mismatches;
	int cycle_count;
	bit src_gaps_on;
	bit sink_stalls_on;

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Fixed-point filter prediction
	// ------------------------------------------------------------------------

	function automatic longint clamp_sample(input longint v);
		if (v > SAMPLE_MAX)
			return SAMPLE_MAX;
		if (v < SAMPLE_MIN)
			return SAMPLE_MIN;
		return v;
	endfunction

	// add half an LSB, then floor: ties go towards plus infinity
	function automatic longint round_half_up(input longint v, input int frac);
		return (v + (longint'(1) << (frac - 1))) >>> frac;
	endfunction

	function automatic void clear_filter_state();
		tap_b0   = COEF_W'(COEF_ONE);
		tap_b1   = '0;
		tap_b2   = '0;
		tap_a1   = '0;
		tap_a2   = '0;
		gain_q14 = GAIN_RESET;
		x_prev1  = '0;
		x_prev2  = '0;
		y_prev1  = '0;
		y_prev2  = '0;
	endfunction

	function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		case (idx)
			REG_B0:   tap_b0   = data[COEF_W-1:0];
			REG_B1:   tap_b1   = data[COEF_W-1:0];
			REG_B2:   tap_b2   = data[COEF_W-1:0];
			REG_A1:   tap_a1   = data[COEF_W-1:0];
			REG_A2:   tap_a2   = data[COEF_W-1:0];
			REG_GAIN: gain_q14 = data[GAIN_W-1:0];
			default:  ;
		endcase
	endfunction

	// One sample through the section: the clamped filter value enters the
	// output history, the gain stage only shapes what leaves.
	function automatic logic signed [SW-1:0] biquad_step(input logic signed [SW-1:0] x);
		longint acc;
		longint y;
		acc = longint'(tap_b0) * longint'(x)
			+ longint'(tap_b1) * longint'(x_prev1)
			+ longint'(tap_b2) * longint'(x_prev2)
			- longint'(tap_a1) * longint'(y_prev1)
			- longint'(tap_a2) * longint'(y_prev2);
		y = clamp_sample(round_half_up(acc, COEF_FRAC));
		x_prev2 = x_prev1;
		x_prev1 = x;
		y_prev2 = y_prev1;
		y_prev1 = SW'(y);
		return SW'(clamp_sample(round_half_up(y * longint'(gain_q14), GAIN_FRAC)));
	endfunction

	// ------------------------------------------------------------------------
	// Shared drivers
	// ------------------------------------------------------------------------

	function automatic void report_failure(input string what,
			input logic signed [SW-1:0] want, input logic signed [SW-1:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
	endfunction

	// Send one sample. Before the transfer, sometimes drop valid for a burst;
	// half of those bursts start only once the block shows ready, so the gap
	// lands right where it would have taken the sample.
	task automatic send_sample(input logic signed [SW-1:0] x);
		if (src_gaps_on && $urandom_range(0, 2) == 0) begin
			samples_ch.valid <= 1'b0;
			if ($urandom_range(0, 1) == 0) begin
				do @(posedge clk); while (!samples_ch.ready);
			end
			repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
		end
		samples_ch.valid     <= 1'b1;
		samples_ch.sample_in <= x;
		do @(posedge clk); while (!samples_ch.ready);
		owed_samples.push_back(biquad_step(x));
	endtask

	// Drop valid and hold until every owed result has been transferred.
	// It always waits on a clock edge before it checks, so two calls never share a step.
	task automatic hold_for_results();
		samples_ch.valid <= 1'b0;
		do @(posedge clk); while (owed_samples.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		apply_reg_write(idx, data);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic load_filter(input logic [CFG_W-1:0] b0, input logic [CFG_W-1:0] b1,
			input logic [CFG_W-1:0] b2, input logic [CFG_W-1:0] a1,
			input logic [CFG_W-1:0] a2, input logic [CFG_W-1:0] gain);
		hold_for_results();
		write_reg(REG_B0, b0);
		write_reg(REG_B1, b1);
		write_reg(REG_B2, b2);
		write_reg(REG_A1, a1);
		write_reg(REG_A2, a2);
		write_reg(REG_GAIN, gain);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset leaves b0 at one and the gain at one half: the section passes the
	// sample and halves it. Minus one lands on a tie and must round up to zero.
	task automatic test_reset_defaults();
		send_sample('0);
		send_sample(SW'(1));
		send_sample(SW'(-1));
		send_sample(SW'(SAMPLE_MAX));
		send_sample(SW'(SAMPLE_MIN));
		send_sample(SW'(2));
		send_sample(SW'(-3));
	endtask

	// With b0 at one half, odd samples give exact half-LSB ties in the filter
	// rounding: plus 1.5 rounds to 2, minus 1.5 to minus 1.
	task automatic test_rounding_ties();
		load_filter(CFG_W'(COEF_ONE / 2), '0, '0, '0, '0, CFG_W'(GAIN_ONE));
		send_sample(SW'(1));
		send_sample(SW'(-1));
		send_sample(SW'(3));
		send_sample(SW'(-3));
	endtask

	// Largest coefficients of both signs and the largest gain drive both
	// clamps hard; a zero gain must then silence a full-scale sample.
	task automatic test_saturation();
		load_filter(CFG_W'(COEF_MAX), CFG_W'(COEF_MIN), CFG_W'(COEF_MAX),
			CFG_W'(COEF_MIN), CFG_W'(COEF_MAX), CFG_W'(GAIN_MAX));
		send_sample(SW'(SAMPLE_MAX));
		send_sample(SW'(SAMPLE_MIN));
		send_sample(SW'(SAMPLE_MAX));
		send_sample('0);
		hold_for_results();
		write_reg(REG_GAIN, '0);
		send_sample(SW'(SAMPLE_MAX));
	endtask

	// Unstable feedback (a1 = -2, a2 = 1) after a full-scale
	// impulse: the output history must carry the clamped value, not the sum.
	task automatic test_clamped_history();
		load_filter(CFG_W'(COEF_ONE), '0, '0, CFG_W'(-2 * COEF_ONE), CFG_W'(COEF_ONE),
			CFG_W'(GAIN_ONE));
		send_sample(SW'(SAMPLE_MAX));
		repeat (4) send_sample('0);
	endtask

	// Writes past the register map go nowhere; gain keeps only its own bits.
	task automatic test_register_decode();
		hold_for_results();
		write_reg(UNMAPPED_FIRST, '1);
		write_reg(UNMAPPED_LAST, '1);
		write_reg(REG_GAIN, {{(CFG_W - GAIN_W){1'b1}}, GAIN_W'(GAIN_ONE)});
		send_sample(SW'(-4096));
		send_sample(SW'(SAMPLE_MAX));
	endtask

	function automatic logic [CFG_W-1:0] pick_coef(input coef_style_t style);
		case (style)
			SET_GENTLE:  return CFG_W'(int'($urandom_range(0, 2 * COEF_ONE)) - COEF_ONE);
			SET_FULL:    return CFG_W'($urandom());
			default: begin
				case ($urandom_range(0, 3))
					0:       return CFG_W'(COEF_MAX);
					1:       return CFG_W'(COEF_MIN);
					2:       return CFG_W'(COEF_ONE);
					default: return '0;
				endcase
			end
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_gain(input coef_style_t style);
		case (style)
			SET_GENTLE:  return CFG_W'($urandom_range(0, 2 * GAIN_ONE));
			SET_FULL:    return CFG_W'($urandom());
			default: begin
				case ($urandom_range(0, 2))
					0:       return CFG_W'(GAIN_MAX);
					1:       return CFG_W'(GAIN_ONE);
					default: return '0;
				endcase
			end
		endcase
	endfunction

	// Full-scale noise half the time, with quiet passages and rail-to-rail samples
	function automatic logic signed [SW-1:0] pick_sample();
		case ($urandom_range(0, 9))
			5, 6, 7: return SW'(int'($urandom_range(0, 8192)) - 4096);
			8:       return ($urandom_range(0, 1) == 1) ? SW'(SAMPLE_MAX) : SW'(SAMPLE_MIN);
			9:       return '0;
			default: return SW'($urandom());
		endcase
	endfunction

	// Phases of random samples, each under a fresh filter. The first phases
	// pin the extremes; the last two run with both channels flat out.
	task automatic test_random_filters();
		coef_style_t style;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: load_filter(CFG_W'(COEF_MAX), CFG_W'(COEF_MAX), CFG_W'(COEF_MAX),
					CFG_W'(COEF_MAX), CFG_W'(COEF_MAX), CFG_W'(GAIN_MAX));
				1: load_filter(CFG_W'(COEF_MIN), CFG_W'(COEF_MIN), CFG_W'(COEF_MIN),
					CFG_W'(COEF_MIN), CFG_W'(COEF_MIN), '0);
				default: begin
					style = coef_style_t'($urandom_range(SET_GENTLE, SET_CORNERS));
					if (p == 2)
						style = SET_GENTLE;
					else if (p == 3)
						style = SET_FULL;
					load_filter(pick_coef(style), pick_coef(style), pick_coef(style),
						pick_coef(style), pick_coef(style), pick_gain(style));
				end
			endcase
			if (p >= RANDOM_PHASES - 2) begin
				src_gaps_on    = 1'b0;
				sink_stalls_on = 1'b0;
			end else begin
				src_gaps_on    = (p % 3) != 1;
				sink_stalls_on = (p % 3) != 2;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// mid-phase, let the block run completely dry before carrying on
				if (i == PHASE_ITEMS / 2)
					hold_for_results();
				send_sample(pick_sample());
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Result checking: compare each transfer on the result channel with the
	// oldest owed sample. Sampled at the edge, so both sides see the values
	// from before it.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (owed_samples.size() == 0)
				report_failure("result with nothing owed", 'x, results_ch.sample_out);
			else if (results_ch.sample_out !== owed_samples[0])
				report_failure("sample_out mismatch", owed_samples[0], results_ch.sample_out);
			if (owed_samples.size() != 0)
				void'(owed_samples.pop_front());
		end
	end

	// Result sink: ready drops in random bursts while stalls are enabled,
	// otherwise stays high.
	initial begin
		results_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (sink_stalls_on && $urandom_range(0, 15) == 0) begin
				results_ch.ready <= 1'b0;
				repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
			end
			results_ch.ready <= 1'b1;
		end
	end

	// Watchdog: a correct run ends well before this limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, owed_samples.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sequence: reset once, directed checks, random phases, then drain.
	// ------------------------------------------------------------------------
	initial begin
		mismatches     = 0;
		cycle_count    = 0;
		src_gaps_on    = 1'b1;
		sink_stalls_on = 1'b1;
		clear_filter_state();
		arst_n               <= 1'b0;
		samples_ch.valid     <= 1'b0;
		samples_ch.sample_in <= '0;
		cfg_we               <= 1'b0;
		cfg_index            <= '0;
		cfg_data             <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_rounding_ties();
		test_saturation();
		test_clamped_history();
		test_register_decode();
		test_random_filters();

		// Collect the tail, then give any stray result time to show up
		hold_for_results();
		repeat (ITEM_CYCLES) @(posedge clk);
		if (mismatches == 0 && owed_samples.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
